>>> sv/b64d_pkg.sv
// shared types, constants and symbol mapping for the base64url decoder
package b64d_pkg;

  localparam logic [6:0] SYM_PAD = 7'd65;
  localparam logic [6:0] SYM_BAD = 7'd66;

  typedef struct packed {
    logic [7:0] symbol;
    logic       symbol_present;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       final_result;
    logic       bad_input;
  } result_t;

  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  nbytes;
    logic        is_final;
    logic        bad;
  } work_t;

  function automatic logic [6:0] sym_map(input logic [7:0] c);
    logic [6:0] v;
    v = SYM_BAD;
    if (c >= 8'h41 && c <= 8'h5a) begin
      v = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      v = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2d) begin
      v = 7'd62;
    end else if (c == 8'h5f) begin
      v = 7'd63;
    end else if (c == 8'h3d) begin
      v = SYM_PAD;
    end
    return v;
  endfunction

endpackage

>>> sv/b64d_front.sv
// front end: symbol decode, bit packing and end-of-text flush into work entries
module b64d_front import b64d_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  take,
  input  item_t item,
  output logic  work_push,
  output work_t work
);

  logic [17:0] pending_bits, pending_bits_next;
  logic [1:0]  pending_count, pending_count_next;
  logic        pad_seen, pad_seen_next;
  logic        error_seen, error_seen_next;
  logic [6:0]  v;

  always_comb begin
    v = sym_map(item.symbol);
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    pad_seen_next      = pad_seen;
    error_seen_next    = error_seen;
    work               = '0;
    if (item.symbol_present && !pad_seen && !error_seen) begin
      if (v == SYM_BAD) begin
        error_seen_next = 1'b1;
      end else if (v == SYM_PAD) begin
        pad_seen_next = 1'b1;
      end else if (pending_count == 2'd3) begin
        work.word          = {pending_bits, v[5:0]};
        work.nbytes        = 2'd3;
        pending_bits_next  = '0;
        pending_count_next = '0;
      end else begin
        pending_bits_next  = {pending_bits[11:0], v[5:0]};
        pending_count_next = pending_count + 2'd1;
      end
    end
    if (item.end_of_text) begin
      if (!error_seen_next) begin
        if (pending_count_next == 2'd3) begin
          work.word   = {pending_bits_next[17:2], 8'h00};
          work.nbytes = 2'd2;
        end else if (pending_count_next == 2'd2) begin
          work.word   = {pending_bits_next[11:4], 16'h0000};
          work.nbytes = 2'd1;
        end
      end
      work.is_final = 1'b1;
      work.bad      = error_seen_next;
      pending_bits_next  = '0;
      pending_count_next = '0;
      pad_seen_next      = 1'b0;
      error_seen_next    = 1'b0;
    end
    work_push = take && (work.nbytes != 2'd0 || item.end_of_text);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
      pad_seen      <= 1'b0;
      error_seen    <= 1'b0;
    end else if (take) begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
      pad_seen      <= pad_seen_next;
      error_seen    <= error_seen_next;
    end
  end

endmodule

>>> sv/b64d_queue.sv
// work entry queue between front and back
module b64d_queue import b64d_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  work_t wr_data,
  input  logic  rd,
  output work_t rd_data,
  output logic  full,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> sv/b64d_back.sv
// back end: splits work entries into byte results and holds the result queue
module b64d_back import b64d_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  work_t   work,
  input  logic    work_empty,
  output logic    work_pop,
  output result_t result,
  output logic    empty,
  input  logic    pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic [1:0]       idx;
  logic             room, emit, last, do_rd;
  result_t          res;

  assign room   = (count != CNT_W'(DEPTH));
  assign emit   = room && !work_empty;
  assign empty  = (count == '0);
  assign do_rd  = pop && !empty;
  assign result = mem[rd_ptr];

  always_comb begin
    res  = '0;
    last = (work.nbytes == 2'd0) || (idx == 2'(work.nbytes - 2'd1));
    if (work.nbytes != 2'd0) begin
      res.byte_valid = 1'b1;
      case (idx)
        2'd0:    res.data_byte = work.word[23:16];
        2'd1:    res.data_byte = work.word[15:8];
        default: res.data_byte = work.word[7:0];
      endcase
    end
    res.final_result = work.is_final && last;
    res.bad_input    = work.is_final && last && work.bad;
    work_pop         = emit && last;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      mem[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (emit) begin
        idx    <= last ? 2'd0 : idx + 2'd1;
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (emit && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !emit) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> sv/base64url_decoder.sv
// top level of the streaming base64url decoder
//
// Input channel: present one character request on item with push high; it is
// taken at a rising edge where push is high and full is low. symbol_present
// low with end_of_text high closes a string without a character.
// Result channel: while empty is low the oldest result sits on result; pop
// high at a rising edge takes it.
// Each fourth alphabet symbol yields three bytes; end_of_text flushes two or
// one held bytes and marks the last result final_result, with bad_input set if
// an invalid character was seen. A string whose end_of_text item brings no byte
// ends in one result with byte_valid low.
// An item's work entry is registered in the work queue and its byte results in
// the result queue. Throughput: one item per cycle while full is low; the back
// end writes one result per cycle while the result queue has room, which
// covers the three bytes of every four symbols.
// When the receiver stalls, the result queue fills, the back end holds its
// entry, the work queue fills and full rises; nothing is dropped.
// Reset clears the decode state and empties both queues.
module base64url_decoder import b64d_pkg::*; #(
  parameter int WORK_DEPTH   = 4,
  parameter int RESULT_DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  item_t   item,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic  take, work_push, work_pop, work_empty;
  work_t work_in, work_out;

  assign take = push && !full;

  b64d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (item),
    .work_push (work_push),
    .work      (work_in)
  );

  b64d_queue #(.DEPTH(WORK_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (work_push),
    .wr_data (work_in),
    .rd      (work_pop),
    .rd_data (work_out),
    .full    (full),
    .empty   (work_empty)
  );

  b64d_back #(.DEPTH(RESULT_DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .work       (work_out),
    .work_empty (work_empty),
    .work_pop   (work_pop),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

>>> tb/tb_base64url_decoder.sv
// self-checking testbench for the streaming base64url decoder
`timescale 1ns / 1ps

module tb_base64url_decoder;
  import b64d_pkg::*;

  localparam int ITEMS       = 320;
  localparam int HOLD_CYCLES = 100;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN       = 20;

  localparam result_t END_CLEAN = {8'h00, 1'b0, 1'b1, 1'b0};
  localparam result_t END_BAD   = {8'h00, 1'b0, 1'b1, 1'b1};
  localparam result_t BYTE_FF   = {8'hff, 1'b1, 1'b0, 1'b0};

  typedef struct packed {
    item_t          req;
    int             n_typed;
    result_t [2:0]  exp_res;
  } text_row_t;

  logic    clk;
  logic    rst;
  logic    push;
  logic    full;
  item_t   item;
  logic    empty;
  logic    pop;
  result_t result;

  base64url_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // decoder state as predicted
  logic [17:0] held_bits;
  logic [1:0]  held_count;
  logic        pad_flag;
  logic        bad_flag;
  result_t     expect_q[$];

  int errors;
  int items_sent;
  int ignored_sent;
  int strings_done;
  int bytes_seen;
  int bad_strings;
  int input_stalls;
  int holds_done;
  int quiet;
  bit burst;
  bit hold_long;
  bit rx_eager;

  text_row_t directed_text[$];

  function automatic logic [6:0] alpha_value(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return 7'(c - "A");
    if (c >= "a" && c <= "z") return 7'(c - "a" + 26);
    if (c >= "0" && c <= "9") return 7'(c - "0" + 52);
    if (c == "-") return 7'd62;
    if (c == "_") return 7'd63;
    if (c == "=") return SYM_PAD;
    return SYM_BAD;
  endfunction

  function automatic void predict_decode(input item_t req);
    logic [6:0]  v;
    logic [23:0] w;
    result_t     r;
    int          n0;
    n0 = expect_q.size();
    if (req.symbol_present && !pad_flag && !bad_flag) begin
      v = alpha_value(req.symbol);
      if (v == SYM_BAD) begin
        bad_flag = 1'b1;
      end else if (v == SYM_PAD) begin
        pad_flag = 1'b1;
      end else if (held_count == 2'd3) begin
        w = {held_bits, v[5:0]};
        expect_q.push_back({w[23:16], 1'b1, 1'b0, 1'b0});
        expect_q.push_back({w[15:8], 1'b1, 1'b0, 1'b0});
        expect_q.push_back({w[7:0], 1'b1, 1'b0, 1'b0});
        held_bits  = '0;
        held_count = '0;
      end else begin
        held_bits  = {held_bits[11:0], v[5:0]};
        held_count = held_count + 2'd1;
      end
    end
    if (req.end_of_text) begin
      if (!bad_flag) begin
        if (held_count == 2'd3) begin
          expect_q.push_back({held_bits[17:10], 1'b1, 1'b0, 1'b0});
          expect_q.push_back({held_bits[9:2], 1'b1, 1'b0, 1'b0});
        end else if (held_count == 2'd2) begin
          expect_q.push_back({held_bits[11:4], 1'b1, 1'b0, 1'b0});
        end
      end
      if (expect_q.size() == n0) expect_q.push_back({8'h00, 1'b0, 1'b0, 1'b0});
      r = expect_q.pop_back();
      r.final_result = 1'b1;
      r.bad_input    = bad_flag;
      expect_q.push_back(r);
      held_bits  = '0;
      held_count = '0;
      pad_flag   = 1'b0;
      bad_flag   = 1'b0;
    end
  endfunction

  function automatic text_row_t text_row(input logic [7:0] c, input logic p, input logic e,
                                         input int n = -1, input result_t r0 = '0,
                                         input result_t r1 = '0, input result_t r2 = '0);
    text_row_t r;
    r.req        = {c, p, e};
    r.n_typed    = n;
    r.exp_res[0] = r0;
    r.exp_res[1] = r1;
    r.exp_res[2] = r2;
    return r;
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] alpha_char();
    int idx;
    idx = $urandom_range(0, 63);
    if (idx < 26) return 8'("A" + idx);
    if (idx < 52) return 8'("a" + idx - 26);
    if (idx < 62) return 8'("0" + idx - 52);
    if (idx == 62) return "-";
    return "_";
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (alpha_value(c) != SYM_BAD);
    return c;
  endfunction

  task automatic offer_request(input text_row_t r);
    int g;
    int n0;
    int k;
    g = burst ? 0 : rand_gap();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    push <= 1'b1;
    item <= r.req;
    @(posedge clk);
    while (full) begin
      input_stalls++;
      @(posedge clk);
    end
    n0 = expect_q.size();
    predict_decode(r.req);
    if (r.n_typed >= 0) begin
      while (expect_q.size() > n0) void'(expect_q.pop_back());
      for (k = 0; k < r.n_typed; k++) expect_q.push_back(r.exp_res[k]);
    end
    if (r.req.symbol_present || r.req.end_of_text) items_sent++;
    else ignored_sent++;
  endtask

  task automatic send_string();
    int         kind;
    int         len;
    int         i;
    bit         end_on_sym;
    logic [7:0] text[$];
    kind = $urandom_range(0, 99);
    len  = $urandom_range(0, 14);
    for (i = 0; i < len; i++) begin
      if (kind >= 95) text.push_back(8'($urandom_range(0, 255)));
      else text.push_back(alpha_char());
    end
    if (len > 0 && kind >= 70 && kind < 85) text[$urandom_range(0, len - 1)] = "=";
    if (len > 0 && kind >= 85 && kind < 95) text[$urandom_range(0, len - 1)] = bad_char();
    end_on_sym = (len > 0) && ($urandom_range(0, 1) == 1);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        offer_request(text_row(8'($urandom_range(0, 255)), 1'b0, 1'b0));
      end
      offer_request(text_row(text[i], 1'b1, end_on_sym && i == len - 1));
    end
    if (!end_on_sym) offer_request(text_row(8'($urandom_range(0, 255)), 1'b0, 1'b1));
  endtask

  task automatic drain_results();
    int      g;
    result_t want;
    forever begin
      if (hold_long) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_long = 1'b0;
        holds_done++;
      end else begin
        g = rx_eager ? 0 : rand_gap();
        if (g > 0) begin
          pop <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
      pop <= 1'b1;
      @(posedge clk);
      if (!empty) begin
        if (result.byte_valid) bytes_seen++;
        if (result.final_result) strings_done++;
        if (result.final_result && result.bad_input) bad_strings++;
        if (expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: byte=%h valid=%b final=%b bad=%b", $time,
                   result.data_byte, result.byte_valid, result.final_result,
                   result.bad_input);
        end else begin
          want = expect_q.pop_front();
          if (result.data_byte !== want.data_byte || result.byte_valid !== want.byte_valid ||
              result.final_result !== want.final_result ||
              result.bad_input !== want.bad_input) begin
            errors++;
            $display("%0t: mismatch: expected %h/%b/%b/%b got %h/%b/%b/%b",
                     $time, want.data_byte, want.byte_valid, want.final_result,
                     want.bad_input, result.data_byte, result.byte_valid,
                     result.final_result, result.bad_input);
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: watchdog: no request moved for %0d cycles", $time, quiet);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int  mark;
    bit  pressure_done;
    rst  = 1'b1;
    push = 1'b0;
    pop  = 1'b0;
    item = '0;
    errors = 0;
    items_sent = 0;
    ignored_sent = 0;
    strings_done = 0;
    bytes_seen = 0;
    bad_strings = 0;
    input_stalls = 0;
    holds_done = 0;
    burst = 1'b0;
    hold_long = 1'b0;
    rx_eager = 1'b0;
    pressure_done = 1'b0;
    held_bits = '0;
    held_count = '0;
    pad_flag = 1'b0;
    bad_flag = 1'b0;

    // end-only, all-ones, flush of one/two/three held, pad, errors, ignored
    directed_text.push_back(text_row(8'h00, 1'b0, 1'b1, 1, END_CLEAN));
    directed_text.push_back(text_row("_", 1'b1, 1'b0));
    directed_text.push_back(text_row("_", 1'b1, 1'b0));
    directed_text.push_back(text_row("_", 1'b1, 1'b0));
    directed_text.push_back(text_row("_", 1'b1, 1'b0, 3, BYTE_FF, BYTE_FF, BYTE_FF));
    directed_text.push_back(text_row("A", 1'b1, 1'b1, 1, END_CLEAN));
    directed_text.push_back(text_row("T", 1'b1, 1'b0));
    directed_text.push_back(text_row("W", 1'b1, 1'b0));
    directed_text.push_back(text_row("F", 1'b1, 1'b1));
    directed_text.push_back(text_row("-", 1'b1, 1'b0));
    directed_text.push_back(text_row("0", 1'b1, 1'b1));
    directed_text.push_back(text_row("z", 1'b1, 1'b0));
    directed_text.push_back(text_row("=", 1'b1, 1'b0));
    directed_text.push_back(text_row("Q", 1'b1, 1'b0));
    directed_text.push_back(text_row(8'h00, 1'b0, 1'b1));
    directed_text.push_back(text_row("a", 1'b1, 1'b0));
    directed_text.push_back(text_row(8'hff, 1'b1, 1'b0));
    directed_text.push_back(text_row("b", 1'b1, 1'b0));
    directed_text.push_back(text_row("9", 1'b1, 1'b1, 1, END_BAD));
    directed_text.push_back(text_row(8'h00, 1'b1, 1'b1, 1, END_BAD));
    directed_text.push_back(text_row(8'h80, 1'b0, 1'b0, 0));
    directed_text.push_back(text_row("a", 1'b1, 1'b0));
    directed_text.push_back(text_row("Z", 1'b1, 1'b0));
    directed_text.push_back(text_row("0", 1'b1, 1'b0));
    directed_text.push_back(text_row("_", 1'b1, 1'b0));
    directed_text.push_back(text_row("*", 1'b1, 1'b1, 1, END_BAD));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    fork
      drain_results();
    join_none

    foreach (directed_text[k]) offer_request(directed_text[k]);

    while (items_sent < ITEMS) begin
      if (!pressure_done && items_sent >= 140) begin
        // receiver stalls while requests keep coming, then the sender waits it out
        hold_long = 1'b1;
        burst = 1'b1;
        mark = items_sent;
        while (items_sent < mark + 40) send_string();
        burst = 1'b0;
        pressure_done = 1'b1;
        push <= 1'b0;
        do @(posedge clk); while (expect_q.size() != 0);
      end
      rx_eager = (items_sent >= 220 && items_sent < 260);
      send_string();
    end
    rx_eager = 1'b0;

    push <= 1'b0;
    do @(posedge clk); while (expect_q.size() != 0);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d requests (%0d ignored) in %0d strings: %0d bytes, %0d flagged bad",
             items_sent, ignored_sent, strings_done, bytes_seen, bad_strings);
    $display("input stalled %0d cycles, receiver long hold-offs %0d, errors %0d",
             input_stalls, holds_done, errors);
    if (errors == 0 && expect_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/b64d_pkg.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64url_decoder.sv
tb/tb_base64url_decoder.sv
